FILE: rtl/css_min_pkg.sv
// shared types for the css whitespace and comment stripper
// one result item and the group of up to two results made per input item
`default_nettype none
package css_min_pkg;

	localparam int unsigned MAX_RES = 2;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last_out;
	} result_t;

	typedef struct packed {
		logic [1:0]          cnt;
		result_t [MAX_RES-1:0] slot;
	} step_res_t;

endpackage
`default_nettype wire

FILE: rtl/css_min_core.sv
// scanner state and per-byte decision logic of the css stripper
// depends on css_min_pkg for the result group type
`default_nettype none
module css_min_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            in_byte,
	input  logic                  last_in,
	output css_min_pkg::step_res_t res
);
	import css_min_pkg::*;

	typedef enum logic [2:0] {
		M_SKIP     = 3'd0,
		M_SOLID    = 3'd1,
		M_GAP      = 3'd2,
		M_STR      = 3'd3,
		M_ESC      = 3'd4,
		M_CMT      = 3'd5,
		M_CMT_STAR = 3'd6
	} mode_t;

	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_LBRC  = 8'h7b;
	localparam logic [7:0] CH_RBRC  = 8'h7d;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_LBRK  = 8'h5b;
	localparam logic [7:0] CH_RBRK  = 8'h5d;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;

	function automatic logic is_space(input logic [7:0] b);
		return b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_CR;
	endfunction

	function automatic logic is_sep(input logic [7:0] b);
		return b == CH_SEMI || b == CH_COMMA || b == CH_COLON || b == CH_LBRC ||
			b == CH_RBRC || b == CH_LPAR || b == CH_RPAR || b == CH_LBRK ||
			b == CH_RBRK;
	endfunction

	mode_t      mode_q, mode_n;
	logic       slash_q, slash_n;
	logic       quote_q, quote_n;
	logic [7:0] prev_q, prev_n;

	logic       do_solid;
	logic       pre_space;
	logic       sp;
	logic [7:0] qch;
	logic [7:0] eb [MAX_RES];
	logic [1:0] cnt;

	always_comb begin
		sp        = is_space(in_byte);
		qch       = quote_q ? CH_SQ : CH_DQ;
		mode_n    = mode_q;
		slash_n   = slash_q;
		quote_n   = quote_q;
		prev_n    = prev_q;
		do_solid  = 1'b0;
		pre_space = 1'b0;
		cnt       = 2'd0;
		eb[0]     = 8'h00;
		eb[1]     = 8'h00;

		case (mode_q)
			M_SOLID: begin
				do_solid = 1'b1;
			end
			M_GAP: begin
				if (!sp) begin
					pre_space = !is_sep(prev_q) && !is_sep(in_byte);
					do_solid  = 1'b1;
				end
			end
			M_STR: begin
				eb[cnt[0]] = in_byte;
				cnt        = cnt + 2'd1;
				if (in_byte == CH_BSL) begin
					mode_n = M_ESC;
				end else if (in_byte == qch) begin
					mode_n = M_SOLID;
				end
			end
			M_ESC: begin
				eb[cnt[0]] = in_byte;
				cnt        = cnt + 2'd1;
				mode_n     = M_STR;
			end
			M_CMT: begin
				if (in_byte == CH_STAR) begin
					mode_n = M_CMT_STAR;
				end
			end
			M_CMT_STAR: begin
				if (in_byte == CH_SLASH) begin
					mode_n = M_SKIP;
				end else if (in_byte != CH_STAR) begin
					mode_n = M_CMT;
				end
			end
			default: begin
				do_solid = !sp;
			end
		endcase

		if (pre_space) begin
			eb[cnt[0]] = CH_SP;
			cnt        = cnt + 2'd1;
		end

		if (do_solid) begin
			if (slash_q && in_byte == CH_STAR) begin
				slash_n = 1'b0;
				mode_n  = M_CMT;
			end else begin
				if (slash_q) begin
					eb[cnt[0]] = CH_SLASH;
					cnt        = cnt + 2'd1;
				end
				slash_n = 1'b0;
				if (sp) begin
					mode_n = M_GAP;
				end else if (in_byte == CH_DQ || in_byte == CH_SQ) begin
					eb[cnt[0]] = in_byte;
					cnt        = cnt + 2'd1;
					quote_n    = in_byte == CH_SQ;
					mode_n     = M_STR;
				end else if (in_byte == CH_SLASH) begin
					slash_n = 1'b1;
					mode_n  = M_SOLID;
				end else begin
					eb[cnt[0]] = in_byte;
					cnt        = cnt + 2'd1;
					mode_n     = M_SOLID;
				end
			end
		end

		if (last_in && slash_n) begin
			eb[cnt[0]] = CH_SLASH;
			cnt        = cnt + 2'd1;
		end

		if (cnt == 2'd1) begin
			prev_n = eb[0];
		end else if (cnt == 2'd2) begin
			prev_n = eb[1];
		end

		res.cnt                  = cnt;
		res.slot[0].out_byte     = eb[0];
		res.slot[0].byte_valid   = cnt != 2'd0;
		res.slot[0].last_out     = last_in && cnt != 2'd2;
		res.slot[1].out_byte     = eb[1];
		res.slot[1].byte_valid   = 1'b1;
		res.slot[1].last_out     = last_in;
		if (last_in && cnt == 2'd0) begin
			res.cnt = 2'd1;
		end

		if (last_in) begin
			mode_n  = M_SKIP;
			slash_n = 1'b0;
			quote_n = 1'b0;
			prev_n  = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_SKIP;
			slash_q <= 1'b0;
			quote_q <= 1'b0;
			prev_q  <= 8'h00;
		end else if (step) begin
			mode_q  <= mode_n;
			slash_q <= slash_n;
			quote_q <= quote_n;
			prev_q  <= prev_n;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/css_min_fifo.sv
// four-entry result queue, takes up to two results and gives one per cycle while out_ready is high
// depends on css_min_pkg for the result types
`default_nettype none
module css_min_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  css_min_pkg::step_res_t push_res,
	output logic                  room,
	output logic                  out_valid,
	input  logic                  out_ready,
	output css_min_pkg::result_t   out_item,
	output logic [2:0]            level
);
	import css_min_pkg::*;

	result_t    mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic       pop;
	logic [1:0] n_in;

	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != 3'd0;
	assign out_item  = mem_q[rd_q];
	assign room      = (cnt_q - {2'b00, pop}) <= 3'd2;
	assign n_in      = push ? push_res.cnt : 2'd0;
	assign level     = cnt_q;

	always_ff @(posedge clk) begin
		if (n_in != 2'd0) begin
			mem_q[wr_q] <= push_res.slot[0];
		end
		if (n_in == 2'd2) begin
			mem_q[wr_q + 2'd1] <= push_res.slot[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wr_q  <= wr_q + n_in;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, n_in} - {2'b00, pop};
		end
	end

endmodule
`default_nettype wire

FILE: rtl/css_whitespace_comment_stripper_unit.sv
// top level of the css whitespace and comment stripper
// depends on css_min_pkg, css_min_core and css_min_fifo
// Takes one byte of css text per item and gives the minified bytes, one per
// output item. An input byte is registered, decided combinationally and its zero
// to two results are written to a four-entry queue, so a byte is taken in every
// cycle as long as the queue keeps room for two results; the output side gives
// one result per cycle while m_tready is high. An accepted byte passes the
// input register and the queue before its first result. A text whose bytes all
// vanish ends in one item with tuser low, tdata zero and tlast high.
`default_nettype none
module css_whitespace_comment_stripper_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // in_byte
	input  logic       s_tlast,  // last_in
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // out_byte
	output logic       m_tuser,  // byte_valid
	output logic       m_tlast   // last_out
);
	import css_min_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       room;
	logic       adv;
	step_res_t  res;
	result_t    item;
	logic [2:0] level;

	assign adv      = vld_s1 && room;
	assign s_tready = !vld_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	css_min_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.in_byte (byte_s1),
		.last_in (last_s1),
		.res     (res)
	);

	css_min_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv),
		.push_res  (res),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (item),
		.level     (level)
	);

	assign m_tdata = item.out_byte;
	assign m_tuser = item.byte_valid;
	assign m_tlast = item.last_out;

	a_level: assert property (@(posedge clk) disable iff (!arst_n) level <= 3'd4)
		else $error("result queue overfilled");
	a_empty_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata == 8'h00)
		else $error("empty end marker not last or not zero");
	a_last_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |-> res.cnt != 2'd0)
		else $error("final byte gave no result");
	a_room_push: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.cnt != 2'd0 |=> level <= 3'd4 && level != 3'd0)
		else $error("push lost");

endmodule
`default_nettype wire
